[rtl/core/ccmc_pkg.sv]
// Shared constants, register codes and types for the minimum-coin change engine.
package ccmc_pkg;

  localparam int SLOTS          = 6;
  localparam int NUM_COINS      = 6;
  localparam int MAX_AMOUNT_DEF = 1023;

  localparam int AMT_W   = 10;
  localparam int VAL_W   = 10;
  localparam int CNT_W   = 10;
  localparam int SEL_W   = 3;
  localparam int BEST_W  = 11;
  localparam int ENTRY_W = BEST_W + SEL_W;

  localparam logic [BEST_W-1:0] UNREACHED = '1;

  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 64;
  localparam int OUT_PAD_W  = OUT_DATA_W - SLOTS * CNT_W;

  localparam int APB_AW = 5;
  localparam int APB_DW = 32;

  typedef logic [2:0] reg_idx_t;
  localparam reg_idx_t REG_COINS_IN_USE = 3'd0;
  localparam reg_idx_t REG_COIN_VALUE_0 = 3'd1;
  localparam reg_idx_t REG_COIN_VALUE_5 = 3'd6;

  typedef struct packed {
    logic [SEL_W-1:0]              coins_in_use;
    logic [SLOTS-1:0][VAL_W-1:0]   coin_value;
  } cfg_t;

  typedef struct packed {
    logic                          reachable;
    logic [SLOTS-1:0][CNT_W-1:0]   coin_count;
  } result_t;

  typedef struct packed {
    logic [SEL_W-1:0]  pick;
    logic [BEST_W-1:0] best;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_ROW,
    ST_WALK_RD,
    ST_WALK_UPD,
    ST_DONE
  } state_t;

endpackage

[rtl/core/ccmc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module ccmc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/ccmc_regs.sv]
// APB register file holding the coin count and the coin denominations.
module ccmc_regs
  import ccmc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  reg_idx_t idx;
  reg_idx_t slot;
  logic     wr_en;

  assign idx    = paddr[APB_AW-1:2];
  assign slot   = idx - REG_COIN_VALUE_0;
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.coins_in_use <= SEL_W'(1);
      for (int k = 0; k < SLOTS; k++) begin
        cfg.coin_value[k] <= VAL_W'(1);
      end
    end else if (wr_en) begin
      unique case (idx) inside
        REG_COINS_IN_USE: cfg.coins_in_use <= pwdata[SEL_W-1:0];
        [REG_COIN_VALUE_0:REG_COIN_VALUE_5]: cfg.coin_value[slot] <= pwdata[VAL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx) inside
      REG_COINS_IN_USE: prdata = APB_DW'(cfg.coins_in_use);
      [REG_COIN_VALUE_0:REG_COIN_VALUE_5]: prdata = APB_DW'(cfg.coin_value[slot]);
      default: prdata = '0;
    endcase
  end

endmodule

[rtl/core/ccmc_engine.sv]
// Table-filling sequencer with one shared subtract/compare unit and the walk back.
module ccmc_engine
  import ccmc_pkg::*;
#(
  parameter int MAX_AMOUNT = MAX_AMOUNT_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  cfg_t             cfg,
  input  logic             in_vld,
  output logic             in_rdy,
  input  logic [AMT_W-1:0] in_amount,
  output logic             res_vld,
  input  logic             res_rdy,
  output result_t          res
);

  localparam int DEPTH  = MAX_AMOUNT + 1;
  localparam int ADDR_W = $clog2(DEPTH);

  state_t state, state_next;

  logic [AMT_W-1:0] target;
  logic [SEL_W-1:0] n_act;
  logic [AMT_W-1:0] i;
  logic [SEL_W-1:0] j;
  logic             pend_vld;
  logic [SEL_W-1:0] pend_slot;
  logic [BEST_W-1:0] best;
  logic [SEL_W-1:0] pick;
  logic [AMT_W-1:0] rest;
  logic             ok;
  logic [CNT_W-1:0] counts [SLOTS];

  logic [SEL_W-1:0] n_cfg;
  logic             start;
  logic             too_big;
  logic [SEL_W-1:0] sel_idx;
  logic [VAL_W-1:0] coin_sel;
  logic [AMT_W-1:0] sub_a;
  logic [AMT_W:0]   diff;
  logic             borrow;
  logic             row_last;
  logic             rd_issue;
  entry_t           rd_entry;
  logic [BEST_W-1:0] cand;
  logic             upd;
  logic [BEST_W-1:0] best_cur;
  logic [SEL_W-1:0] pick_cur;
  logic             walk_bad;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  entry_t            ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;

  ccmc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rd_entry)
  );

  always_comb begin
    n_cfg = cfg.coins_in_use;
    if (n_cfg > SEL_W'(SLOTS)) n_cfg = SEL_W'(SLOTS);
    if (n_cfg > SEL_W'(NUM_COINS)) n_cfg = SEL_W'(NUM_COINS);
  end

  assign start   = in_vld && in_rdy;
  assign too_big = 32'(in_amount) > 32'(MAX_AMOUNT);

  // Shared unit: one subtractor serves both the table fill (i - coin) and
  // the walk back (rest - coin); its borrow doubles as the coin > amount test.
  assign sel_idx  = (state == ST_WALK_UPD) ? rd_entry.pick : j;
  assign coin_sel = (sel_idx < SEL_W'(SLOTS)) ? cfg.coin_value[sel_idx] : '0;
  assign sub_a    = (state == ST_ROW) ? i : rest;
  assign diff     = {1'b0, sub_a} - {1'b0, coin_sel};
  assign borrow   = diff[AMT_W];

  assign row_last = (j == n_act);
  assign rd_issue = !row_last && (coin_sel != '0) && !borrow;

  // Compare stage works on the word read back for the previous coin.
  assign cand     = rd_entry.best + BEST_W'(1);
  assign upd      = pend_vld && (rd_entry.best != UNREACHED) && (best > cand);
  assign best_cur = upd ? cand : best;
  assign pick_cur = upd ? pend_slot : pick;

  assign walk_bad = (rd_entry.pick >= SEL_W'(SLOTS)) || (coin_sel == '0) || borrow;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = (too_big || in_amount == '0) ? ST_DONE : ST_INIT;
        end
      end
      ST_INIT: state_next = ST_ROW;
      ST_ROW: begin
        if (row_last && i == target) begin
          state_next = (best_cur == UNREACHED) ? ST_DONE : ST_WALK_RD;
        end
      end
      ST_WALK_RD: state_next = ST_WALK_UPD;
      ST_WALK_UPD: begin
        state_next = (walk_bad || diff[AMT_W-1:0] == '0) ? ST_DONE : ST_WALK_RD;
      end
      ST_DONE: begin
        if (res_rdy) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_rdy    = 1'b0;
    res_vld   = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = ADDR_W'(i);
    ram_wdata = '{pick: pick_cur, best: best_cur};
    ram_raddr = ADDR_W'(diff[AMT_W-1:0]);
    unique case (state)
      ST_IDLE: in_rdy = 1'b1;
      ST_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = '0;
      end
      ST_ROW:  ram_we = row_last;
      ST_WALK_RD: ram_raddr = ADDR_W'(rest);
      ST_WALK_UPD: ;
      ST_DONE: res_vld = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          target   <= in_amount;
          n_act    <= n_cfg;
          i        <= AMT_W'(1);
          j        <= '0;
          best     <= UNREACHED;
          pick     <= '0;
          pend_vld <= 1'b0;
          ok       <= !too_big && in_amount == '0;
          for (int k = 0; k < SLOTS; k++) begin
            counts[k] <= '0;
          end
        end
      end
      ST_ROW: begin
        pend_vld  <= rd_issue;
        pend_slot <= j;
        if (!row_last) begin
          best <= best_cur;
          pick <= pick_cur;
          j    <= j + SEL_W'(1);
        end else begin
          best <= UNREACHED;
          pick <= '0;
          j    <= '0;
          i    <= i + AMT_W'(1);
          if (i == target) begin
            ok   <= best_cur != UNREACHED;
            rest <= target;
          end
        end
      end
      ST_WALK_UPD: begin
        if (!walk_bad) begin
          counts[rd_entry.pick] <= counts[rd_entry.pick] + CNT_W'(1);
          rest                  <= diff[AMT_W-1:0];
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    res.reachable = ok;
    for (int k = 0; k < SLOTS; k++) begin
      res.coin_count[k] = counts[k];
    end
  end

  a_coin_index_bounded: assert property (@(posedge clk) disable iff (rst)
    state == ST_ROW |-> j <= n_act)
    else $error("coin index ran past the active slot count");

  a_unreachable_zero: assert property (@(posedge clk) disable iff (rst)
    res_vld && !res.reachable |-> res.coin_count == '0)
    else $error("counts not zero on an unreachable result");

  a_no_read_after_write: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ROW && ram_we) |=> !pend_vld)
    else $error("a table read was pending across the row write");

  a_walk_order: assert property (@(posedge clk) disable iff (rst)
    state == ST_WALK_UPD |-> $past(state) == ST_WALK_RD)
    else $error("walk update without a preceding table read");

endmodule

[rtl/core/coin_change_min_coins.sv]
// Top level of the minimum-coin change engine: config port, engine and output register.
//
//   channel  | direction | word contents
//   ---------+-----------+---------------------------------------------------
//   s_*      | in        | tdata[9:0] amount
//   m_*      | out       | tdata[59:0] coin_count_0..5, 10 bits each; tuser reachable
//   apb      | in/out    | 0x00 coins_in_use, 0x04..0x18 coin_value_0..5
//
// An amount A with n active coins fills table rows 1..A, each row stepping through the
// n coins on the one RAM read port and ending in a write step; the walk back then takes
// a read state and an update state (ST_WALK_RD, ST_WALK_UPD) per coin in the answer.
// s_tready is high only while the engine is idle; a finished word waits in the
// output register, so a new amount may be taken while it is still unread.
// rst is synchronous; the table needs no clearing since every entry is written first.
module coin_change_min_coins
  import ccmc_pkg::*;
#(
  parameter int MAX_AMOUNT = MAX_AMOUNT_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // [9:0] amount
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // [9:0] count 0 ... [59:50] count 5
  output logic                  m_tuser,   // [0] reachable
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_AW-1:0]     paddr,
  input  logic [APB_DW-1:0]     pwdata,
  output logic [APB_DW-1:0]     prdata,
  output logic                  pready
);

  cfg_t    cfg;
  result_t res;
  logic    res_vld;
  logic    res_rdy;

  ccmc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ccmc_engine #(
    .MAX_AMOUNT (MAX_AMOUNT)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_vld    (s_tvalid),
    .in_rdy    (s_tready),
    .in_amount (s_tdata[AMT_W-1:0]),
    .res_vld   (res_vld),
    .res_rdy   (res_rdy),
    .res       (res)
  );

  assign res_rdy = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_vld && res_rdy) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_vld && res_rdy) begin
      m_tdata <= {{OUT_PAD_W{1'b0}}, res.coin_count};
      m_tuser <= res.reachable;
    end
  end

endmodule
